@@ sv/sum_checked_frame_receiver_unit_macros.svh @@
// Assertion macros used by the checker file.
`ifndef SUM_CHECKED_FRAME_RECEIVER_UNIT_MACROS_SVH
`define SUM_CHECKED_FRAME_RECEIVER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SCFR_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SCFR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/scfr_pkg.sv @@
`default_nettype none
package scfr_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned IDX_W  = 9;

  localparam logic [BYTE_W-1:0] HEADER_CODE  = 8'hF1;
  localparam logic [BYTE_W-1:0] TRAILER_CODE = 8'h7E;

  // Fixed positions at the head of a frame
  localparam logic [IDX_W-1:0] POS_HUNT = 9'd0;
  localparam logic [IDX_W-1:0] POS_HDR1 = 9'd1;
  localparam logic [IDX_W-1:0] POS_SEQ  = 9'd2;
  localparam logic [IDX_W-1:0] POS_LEN  = 9'd3;

  // Index of the checksum byte minus the length value
  localparam logic [IDX_W-1:0] SUM_OFFSET = 9'd4;

  typedef struct packed {
    logic [BYTE_W-1:0] frame_byte;
    logic [IDX_W-1:0]  byte_index;
    logic              last;
    logic              frame_ok;
    logic [BYTE_W-1:0] length_field;
  } scfr_res_t;

endpackage
`default_nettype wire

@@ sv/scfr_parser.sv @@
`default_nettype none
module scfr_parser (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [scfr_pkg::BYTE_W-1:0] item_byte,
  input  wire logic                      step,
  output logic                           res_valid,
  output scfr_pkg::scfr_res_t            res
);
  import scfr_pkg::*;

  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic [BYTE_W-1:0] len_r, len_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic              match_r, match_nxt;
  logic [IDX_W-1:0]  sum_pos;
  logic              last;
  logic              ok;

  assign sum_pos = {1'b0, len_r} + SUM_OFFSET;

  // Decode one byte against the frame position
  always_comb begin
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    sum_nxt   = sum_r;
    match_nxt = match_r;
    res_valid = 1'b1;
    last      = 1'b0;
    ok        = 1'b0;
    case (pos_r)
      POS_HUNT: begin
        if (item_byte == HEADER_CODE) begin
          pos_nxt   = POS_HDR1;
          len_nxt   = '0;
          sum_nxt   = '0;
          match_nxt = 1'b0;
        end else begin
          res_valid = 1'b0;
        end
      end
      POS_HDR1: begin
        if (item_byte == HEADER_CODE) begin
          pos_nxt = POS_SEQ;
        end else begin
          res_valid = 1'b0;
          pos_nxt   = POS_HUNT;
          len_nxt   = '0;
          sum_nxt   = '0;
          match_nxt = 1'b0;
        end
      end
      POS_SEQ: begin
        sum_nxt = item_byte;
        pos_nxt = POS_LEN;
      end
      POS_LEN: begin
        sum_nxt = sum_r + item_byte;
        len_nxt = item_byte;
        pos_nxt = pos_r + 9'd1;
      end
      default: begin
        if (pos_r < sum_pos) begin
          sum_nxt = sum_r + item_byte;
          pos_nxt = pos_r + 9'd1;
        end else if (pos_r == sum_pos) begin
          match_nxt = (sum_r == item_byte);
          pos_nxt   = pos_r + 9'd1;
        end else begin
          last = 1'b1;
          ok   = match_r && (item_byte == TRAILER_CODE);
        end
      end
    endcase

    // Drop back to hunting after the end code
    if (last) begin
      pos_nxt   = POS_HUNT;
      len_nxt   = '0;
      sum_nxt   = '0;
      match_nxt = 1'b0;
    end
  end

  // Result fields; the length shows as updated by this byte
  always_comb begin
    res.frame_byte   = item_byte;
    res.byte_index   = pos_r;
    res.last         = last;
    res.frame_ok     = ok;
    res.length_field = (pos_r == POS_HUNT) ? '0 :
                       (pos_r == POS_LEN)  ? item_byte : len_r;
  end

  // Advance state once per consumed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= POS_HUNT;
      len_r   <= '0;
      sum_r   <= '0;
      match_r <= 1'b0;
    end else if (step) begin
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      sum_r   <= sum_nxt;
      match_r <= match_nxt;
    end
  end

endmodule
`default_nettype wire

@@ sv/scfr_out_reg.sv @@
`default_nettype none
module scfr_out_reg (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                load,
  input  wire scfr_pkg::scfr_res_t load_res,
  input  wire logic                out_stall,
  output logic                     free,
  output logic                     valid,
  output scfr_pkg::scfr_res_t      res
);
  import scfr_pkg::*;

  logic      valid_r, valid_nxt;
  scfr_res_t res_r;

  // Slot frees when empty or when its item leaves this cycle
  assign free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (free) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold payload while stalled
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= load_res;
    end
  end

  assign valid = valid_r;
  assign res   = res_r;

endmodule
`default_nettype wire

@@ sv/sum_checked_frame_receiver_unit.sv @@
// Frame receiver for a byte stream from a serial link.
// Input channel: in_valid / in_stall / in_rx_byte, one received byte per item.
// Output channel: out_valid / out_stall plus the echoed byte, its index in the
// frame, last, frame_ok (meaningful on last) and the captured length byte.
// Bytes outside a frame (during the header hunt, or a broken second header
// byte) give no output item; every byte of a frame gives exactly one.
// A byte passes through the input register, then the decode into the result
// register, before it shows on the output.
// Throughput: one byte per cycle while in_stall stays low; the input register and the
// result register are decoupled, so a byte can be taken while a result waits.
// When out_stall is high the result register holds its item; the input
// register still drains bytes that produce no output, and in_stall rises
// only while a byte with a result is held back by a full result register.
// Reset (rst_n low, synchronous) empties both registers and returns the
// parser to the header hunt with length, sum and match flag cleared.
`default_nettype none
module sum_checked_frame_receiver_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [scfr_pkg::BYTE_W-1:0]  in_rx_byte,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [scfr_pkg::BYTE_W-1:0]       out_frame_byte,
  output logic [scfr_pkg::IDX_W-1:0]        out_byte_index,
  output logic                              out_last,
  output logic                              out_frame_ok,
  output logic [scfr_pkg::BYTE_W-1:0]       out_length_field
);
  import scfr_pkg::*;

  logic              s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_consume;
  logic              in_accept;
  logic              res_valid;
  scfr_res_t         res;
  logic              out_free;
  logic              out_load;
  scfr_res_t         out_res;

  // Consume the held byte when its result has room, or when it has none
  assign s1_consume = s1_valid_r && (out_free || !res_valid);
  assign out_load   = s1_consume && res_valid;
  assign in_stall   = s1_valid_r && !s1_consume;
  assign in_accept  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_consume) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  scfr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_byte (s1_byte_r),
    .step      (s1_consume),
    .res_valid (res_valid),
    .res       (res)
  );

  scfr_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (out_load),
    .load_res  (res),
    .out_stall (out_stall),
    .free      (out_free),
    .valid     (out_valid),
    .res       (out_res)
  );

  assign out_frame_byte   = out_res.frame_byte;
  assign out_byte_index   = out_res.byte_index;
  assign out_last         = out_res.last;
  assign out_frame_ok     = out_res.frame_ok;
  assign out_length_field = out_res.length_field;

endmodule
`default_nettype wire

@@ sv/scfr_checker.sv @@
`default_nettype none
`include "sum_checked_frame_receiver_unit_macros.svh"
module scfr_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_stall,
  input wire logic [scfr_pkg::BYTE_W-1:0]  in_rx_byte,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic [scfr_pkg::BYTE_W-1:0]  out_frame_byte,
  input wire logic [scfr_pkg::IDX_W-1:0]   out_byte_index,
  input wire logic                         out_last,
  input wire logic                         out_frame_ok,
  input wire logic [scfr_pkg::BYTE_W-1:0]  out_length_field
);
  import scfr_pkg::*;

  // Hold a stalled item
  `SCFR_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_frame_byte) && $stable(out_byte_index) && $stable(out_last),
    "stalled output item changed")

  // The end code sits at length plus five
  `SCFR_ASSERT_NOW(a_last_index, out_valid && out_last,
    out_byte_index == ({1'b0, out_length_field} + 9'd5), "last byte at wrong index")

  // frame_ok only on the last byte
  `SCFR_ASSERT_NOW(a_ok_on_last, out_valid && out_frame_ok, out_last,
    "frame_ok raised before the end of a frame")

  // Header bytes are the header code with no length yet
  `SCFR_ASSERT_NOW(a_header, out_valid && (out_byte_index == 9'd0 || out_byte_index == 9'd1),
    out_frame_byte == HEADER_CODE && out_length_field == 8'd0 && !out_last,
    "bad header item")

endmodule

bind sum_checked_frame_receiver_unit scfr_checker u_scfr_checker (.*);
`default_nettype wire

@@ sim/frame_tracker_pkg.sv @@
package frame_tracker_pkg;
  import scfr_pkg::*;

  // Track the frame parser and hold the echoes it should produce
  class frame_echo_tracker;
    scfr_res_t         pending_echoes[$];
    logic [IDX_W-1:0]  pos;
    logic [BYTE_W-1:0] len_seen;
    logic [BYTE_W-1:0] sum_acc;
    bit                sum_hit;
    int unsigned       errors;
    int unsigned       echoes_checked;
    int unsigned       frames_closed;
    int unsigned       frames_good;

    function new();
      restart_hunt();
      errors         = 0;
      echoes_checked = 0;
      frames_closed  = 0;
      frames_good    = 0;
    endfunction

    function void restart_hunt();
      pos      = POS_HUNT;
      len_seen = '0;
      sum_acc  = '0;
      sum_hit  = 1'b0;
    endfunction

    // Advance the parser by one accepted item and queue its echo, if any
    function void note_rx_byte(logic [BYTE_W-1:0] b);
      scfr_res_t echo;
      bit        emit;
      emit            = 1'b1;
      echo            = '0;
      echo.frame_byte = b;
      echo.byte_index = pos;
      if (pos == POS_HUNT) begin
        if (b != HEADER_CODE) begin
          restart_hunt();
          emit = 1'b0;
        end else begin
          pos = POS_HDR1;
        end
      end else if (pos == POS_HDR1) begin
        // a broken second header byte is dropped, not retried as a first one
        if (b != HEADER_CODE) begin
          restart_hunt();
          emit = 1'b0;
        end else begin
          pos = POS_SEQ;
        end
      end else if (pos == POS_SEQ) begin
        sum_acc = b;
        pos     = POS_LEN;
      end else if (pos == POS_LEN) begin
        sum_acc  = sum_acc + b;
        len_seen = b;
        pos      = pos + 1'b1;
      end else if (pos < {1'b0, len_seen} + SUM_OFFSET) begin
        sum_acc = sum_acc + b;
        pos     = pos + 1'b1;
      end else if (pos == {1'b0, len_seen} + SUM_OFFSET) begin
        sum_hit = (sum_acc == b);
        pos     = pos + 1'b1;
      end else begin
        echo.last     = 1'b1;
        echo.frame_ok = sum_hit && (b == TRAILER_CODE);
      end
      echo.length_field = len_seen;
      if (emit) pending_echoes.push_back(echo);
      if (echo.last) restart_hunt();
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
    endfunction

    // Check one output item against the oldest queued echo
    function void check_echo(scfr_res_t got);
      scfr_res_t want;
      if (pending_echoes.size() == 0) begin
        errors++;
        $display("%0t: unexpected output item: expected none, actual byte 0x%0h index %0d",
                 $time, got.frame_byte, got.byte_index);
        return;
      end
      want = pending_echoes.pop_front();
      echoes_checked++;
      compare_field("frame_byte", want.frame_byte, got.frame_byte);
      compare_field("byte_index", want.byte_index, got.byte_index);
      compare_field("last", want.last, got.last);
      compare_field("frame_ok", want.frame_ok, got.frame_ok);
      compare_field("length_field", want.length_field, got.length_field);
      if (want.last) frames_closed++;
      if (want.last && want.frame_ok) frames_good++;
    endfunction

    function int unsigned outstanding();
      return pending_echoes.size();
    endfunction

    function void flag_leftovers();
      if (pending_echoes.size() != 0) begin
        errors += pending_echoes.size();
        $display("%0t: %0d expected output items never arrived", $time,
                 pending_echoes.size());
      end
    endfunction
  endclass

endpackage

@@ sim/tb_top.sv @@
module tb_top;
  import scfr_pkg::*;
  import frame_tracker_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 10;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [BYTE_W-1:0] in_rx_byte;
  logic              out_valid;
  logic              out_stall;
  logic [BYTE_W-1:0] out_frame_byte;
  logic [IDX_W-1:0]  out_byte_index;
  logic              out_last;
  logic              out_frame_ok;
  logic [BYTE_W-1:0] out_length_field;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned bytes_sent;
  int unsigned quiet_cycles;

  frame_echo_tracker tracker;

  sum_checked_frame_receiver_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_byte   (out_frame_byte),
    .out_byte_index   (out_byte_index),
    .out_last         (out_last),
    .out_frame_ok     (out_frame_ok),
    .out_length_field (out_length_field)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Stall the output at the current receiver rate
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Sample both channels, check output items and watch for a hang
  always @(posedge clk) begin
    scfr_res_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) tracker.note_rx_byte(in_rx_byte);
      if (out_valid && !out_stall) begin
        got.frame_byte   = out_frame_byte;
        got.byte_index   = out_byte_index;
        got.last         = out_last;
        got.frame_ok     = out_frame_ok;
        got.length_field = out_length_field;
        tracker.check_echo(got);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Offer one item, idling first at the sender rate; hold it until taken
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Send a whole frame with random payload; optionally spoil sum or end code
  task automatic send_frame(input int unsigned len, input logic [BYTE_W-1:0] seq,
                            input bit good_sum, input bit good_end);
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] b;
    int unsigned       i;
    send_byte(HEADER_CODE);
    send_byte(HEADER_CODE);
    send_byte(seq);
    send_byte(len[7:0]);
    sum = seq + len[7:0];
    for (i = 0; i < len; i++) begin
      b   = 8'($urandom_range(255));
      sum = sum + b;
      send_byte(b);
    end
    if (!good_sum) sum = sum + 8'($urandom_range(1, 255));
    send_byte(sum);
    b = 8'($urandom_range(255));
    if (good_end) b = TRAILER_CODE;
    else if (b == TRAILER_CODE) b = ~b;
    send_byte(b);
  endtask

  // Mostly well-formed frames, with noise, broken headers and cut-off frames
  task automatic run_random(input int unsigned idle_in, input int unsigned stall_out,
                            input int unsigned quota);
    int unsigned       stop_at;
    int unsigned       frame_no;
    int unsigned       pick;
    int unsigned       len;
    logic [BYTE_W-1:0] b;
    send_idle_pct  = idle_in;
    recv_stall_pct = stall_out;
    stop_at        = bytes_sent + quota;
    frame_no       = 0;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
      end else if (pick < 14) begin
        send_byte(HEADER_CODE);
        b = 8'($urandom_range(255));
        if (b == HEADER_CODE) b = 8'h00;
        send_byte(b);
      end else if (pick < 18) begin
        // cut the frame short; the following bytes run on into it
        send_byte(HEADER_CODE);
        send_byte(HEADER_CODE);
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(255)));
      end else begin
        if (frame_no == 2) len = 255;
        else if ($urandom_range(99) < 4) len = $urandom_range(200, 255);
        else len = $urandom_range(0, 12);
        send_frame(len, 8'($urandom_range(255)), $urandom_range(99) < 85,
                   $urandom_range(99) < 85);
        frame_no++;
      end
    end
  endtask

  initial begin
    tracker        = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_rx_byte     = '0;
    out_stall      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    bytes_sent     = 0;
    quiet_cycles   = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Noise while hunting, then a header broken at its second byte
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(HEADER_CODE);
    send_byte(8'h00);
    // Empty frame with a good check, a bad end code, then a bad checksum
    send_frame(0, 8'hFF, 1'b1, 1'b1);
    send_frame(1, 8'h00, 1'b1, 1'b0);
    send_frame(0, HEADER_CODE, 1'b0, 1'b1);

    run_random(29, 81, 630);
    run_random(81, 29, 630);
    run_random(0, 0, 630);
    in_valid <= 1'b0;

    // Drain the pipeline
    while (tracker.outstanding() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    tracker.flag_leftovers();

    $display("Sent %0d bytes under three idle mixes; checked %0d echoed bytes.",
             bytes_sent, tracker.echoes_checked);
    $display("Frame ends seen: %0d, of which %0d passed sum and end code.",
             tracker.frames_closed, tracker.frames_good);
    if (tracker.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
